### rtl/kf4_pkg.sv
// ----------------------------------------------------------------------------
// kf4_pkg
// Types, constants and helpers for the Keccak-f[400] sponge.
// ----------------------------------------------------------------------------
package kf4_pkg;

  localparam int LaneW    = 16;
  localparam int NumLanes = 25;
  localparam int MaxRate  = 24;
  localparam int Rounds   = 20;
  localparam int AddrW    = 5;
  localparam int RndW     = 5;
  localparam int RateW    = 5;

  typedef logic [LaneW-1:0] lane_t;
  typedef lane_t [NumLanes-1:0] state_t;

  localparam logic [1:0] OpAbsorb  = 2'd0;
  localparam logic [1:0] OpSqueeze = 2'd1;
  localparam logic [1:0] OpClear   = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    lane_t      data_word;
  } in_t;

  typedef struct packed {
    lane_t out_word;
    logic  last;
  } out_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    lane_t            wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } ram_req_t;

  // Round constants of the LFSR form, truncated to one lane.
  localparam lane_t RoundConst [Rounds] = '{
    16'h0001, 16'h8082, 16'h808A, 16'h8000, 16'h808B,
    16'h0001, 16'h8081, 16'h8009, 16'h008A, 16'h0088,
    16'h8009, 16'h000A, 16'h808B, 16'h008B, 16'h8089,
    16'h8003, 16'h8002, 16'h0080, 16'h800A, 16'h000A
  };

  // Rotation offsets per lane index x + 5y, reduced mod lane width.
  localparam logic [3:0] RhoOff [NumLanes] = '{
    4'd0,  4'd1,  4'd14, 4'd12, 4'd11,
    4'd4,  4'd12, 4'd6,  4'd7,  4'd4,
    4'd3,  4'd10, 4'd11, 4'd9,  4'd7,
    4'd9,  4'd13, 4'd15, 4'd5,  4'd8,
    4'd2,  4'd2,  4'd13, 4'd8,  4'd14
  };

  function automatic lane_t rotl(lane_t v, logic [3:0] s);
    logic [2*LaneW-1:0] t;
    t = {v, v} << s;
    return t[2*LaneW-1:LaneW];
  endfunction

endpackage

### rtl/keccak_f400_sponge.sv
// Absorb of a word that does not end a block: a lane RAM read in idle, a write-back
// in the absorb state, then the next beat. A block-ending absorb adds a permutation:
// a load pass, the 20 rounds and a store pass. Squeeze: a load pass, rate_words output
// beats (stalls on out_ready_i) in one pass of 25 lane rotations, the 20 rounds and a store pass.
// Reset is asynchronous; afterwards, and after a clear op, a zeroing pass
// of the lane RAM runs with in_ready_o low. Configuration is accepted only while idle.
// ----------------------------------------------------------------------------
// keccak_f400_sponge
// Keccak sponge on Keccak-f[400], state held in a lane RAM.
// ----------------------------------------------------------------------------
module keccak_f400_sponge (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  kf4_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output kf4_pkg::out_t                 out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [kf4_pkg::RateW-1:0]     cfg_data_i
);

  localparam logic [2:0] StInit  = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StAbs   = 3'd2;
  localparam logic [2:0] StLoad  = 3'd3;
  localparam logic [2:0] StRnd   = 3'd4;
  localparam logic [2:0] StStore = 3'd5;
  localparam logic [2:0] StEmit  = 3'd6;

  localparam logic [kf4_pkg::AddrW-1:0] LastLane = kf4_pkg::AddrW'(kf4_pkg::NumLanes - 1);
  localparam logic [kf4_pkg::AddrW-1:0] LoadEnd  = kf4_pkg::AddrW'(kf4_pkg::NumLanes);
  localparam logic [kf4_pkg::RndW-1:0]  LastRnd  = kf4_pkg::RndW'(kf4_pkg::Rounds - 1);
  localparam logic [kf4_pkg::RateW-1:0] RateMax  = kf4_pkg::RateW'(kf4_pkg::MaxRate);

  logic [2:0]                  state_q, state_d;
  logic [kf4_pkg::AddrW-1:0]   cnt_q, cnt_d;
  logic [kf4_pkg::RndW-1:0]    rnd_q, rnd_d;
  logic [kf4_pkg::AddrW-1:0]   wi_q, wi_d;
  logic [kf4_pkg::RateW-1:0]   rate_q, rate_d;
  logic                        sqz_q, sqz_d;
  kf4_pkg::lane_t              word_q, word_d;
  kf4_pkg::state_t             work_q, work_d;
  kf4_pkg::out_t               out_q, out_d;
  logic                        out_valid_q, out_valid_d;

  kf4_pkg::ram_req_t           ram_req;
  kf4_pkg::lane_t              ram_rdata;
  kf4_pkg::state_t             round_out;
  kf4_pkg::state_t             work_rot;
  kf4_pkg::state_t             work_shin;

  logic [kf4_pkg::RateW-1:0]   eff_rate;
  logic [kf4_pkg::AddrW-1:0]   next_idx;
  logic                        in_fire;
  logic                        emit_slot;
  logic                        can_load;
  logic                        advance;

  kf4_lane_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  kf4_round u_round (
    .a_i  (work_q),
    .rc_i (kf4_pkg::RoundConst[rnd_q]),
    .a_o  (round_out)
  );

  assign eff_rate = (rate_q == '0) ? kf4_pkg::RateW'(1) :
                    (rate_q > RateMax) ? RateMax : rate_q;

  assign in_ready_o  = (state_q == StIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign next_idx  = ((wi_q >= RateMax) ? '0 : wi_q) + kf4_pkg::AddrW'(1);
  assign emit_slot = (cnt_q < eff_rate);
  assign can_load  = !out_valid_q || out_ready_i;
  assign advance   = emit_slot ? can_load : 1'b1;

  always_comb begin
    work_rot[kf4_pkg::NumLanes-2:0]  = work_q[kf4_pkg::NumLanes-1:1];
    work_rot[kf4_pkg::NumLanes-1]    = work_q[0];
    work_shin[kf4_pkg::NumLanes-2:0] = work_q[kf4_pkg::NumLanes-1:1];
    work_shin[kf4_pkg::NumLanes-1]   = ram_rdata;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rnd_d       = rnd_q;
    wi_d        = wi_q;
    rate_d      = rate_q;
    sqz_d       = sqz_q;
    word_d      = word_q;
    work_d      = work_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    ram_req     = '0;

    if (cfg_valid_i && cfg_ready_o) begin
      rate_d = cfg_data_i;
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StInit: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = cnt_q;
        ram_req.wdata = '0;
        cnt_d         = cnt_q + kf4_pkg::AddrW'(1);
        if (cnt_q == LastLane) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_fire) begin
          if (in_data_i.op == kf4_pkg::OpAbsorb) begin
            ram_req.re    = 1'b1;
            ram_req.raddr = (wi_q >= RateMax) ? '0 : wi_q;
            word_d        = in_data_i.data_word;
            state_d       = StAbs;
          end else if (in_data_i.op == kf4_pkg::OpSqueeze) begin
            sqz_d   = 1'b1;
            wi_d    = '0;
            cnt_d   = '0;
            state_d = StLoad;
          end else if (in_data_i.op == kf4_pkg::OpClear) begin
            wi_d    = '0;
            cnt_d   = '0;
            state_d = StInit;
          end
        end
      end
      StAbs: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = (wi_q >= RateMax) ? '0 : wi_q;
        ram_req.wdata = ram_rdata ^ word_q;
        if (next_idx >= eff_rate) begin
          wi_d    = '0;
          sqz_d   = 1'b0;
          cnt_d   = '0;
          state_d = StLoad;
        end else begin
          wi_d    = next_idx;
          state_d = StIdle;
        end
      end
      StLoad: begin
        // read lane cnt, capture the lane read in the cycle before
        ram_req.re    = (cnt_q != LoadEnd);
        ram_req.raddr = cnt_q;
        if (cnt_q != '0) begin
          work_d = work_shin;
        end
        cnt_d = cnt_q + kf4_pkg::AddrW'(1);
        if (cnt_q == LoadEnd) begin
          cnt_d   = '0;
          rnd_d   = '0;
          state_d = sqz_q ? StEmit : StRnd;
        end
      end
      StEmit: begin
        // rotate all lanes once around; the first eff_rate become beats
        if (advance) begin
          work_d = work_rot;
          cnt_d  = cnt_q + kf4_pkg::AddrW'(1);
          if (emit_slot) begin
            out_d.out_word = work_q[0];
            out_d.last     = (cnt_q == eff_rate - kf4_pkg::RateW'(1));
            out_valid_d    = 1'b1;
          end
          if (cnt_q == LastLane) begin
            cnt_d   = '0;
            rnd_d   = '0;
            state_d = StRnd;
          end
        end
      end
      StRnd: begin
        work_d = round_out;
        rnd_d  = rnd_q + kf4_pkg::RndW'(1);
        if (rnd_q == LastRnd) begin
          cnt_d   = '0;
          state_d = StStore;
        end
      end
      StStore: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = cnt_q;
        ram_req.wdata = work_q[0];
        work_d        = work_rot;
        cnt_d         = cnt_q + kf4_pkg::AddrW'(1);
        if (cnt_q == LastLane) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StInit;
      cnt_q       <= '0;
      rnd_q       <= '0;
      wi_q        <= '0;
      rate_q      <= kf4_pkg::RateW'(8);
      sqz_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rnd_q       <= rnd_d;
      wi_q        <= wi_d;
      rate_q      <= rate_d;
      sqz_q       <= sqz_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    work_q <= work_d;
    out_q  <= out_d;
  end

`ifndef SYNTH
  a_wi_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wi_q < RateMax)
    else $error("absorb index out of range");

  a_ram_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req.we |-> (state_q == StInit || state_q == StAbs || state_q == StStore))
    else $error("lane RAM written outside a write state");

  a_rnd_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRnd && rnd_q == LastRnd) |=> (state_q == StStore && cnt_q == '0))
    else $error("permutation did not hand over to store");

  a_emit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit && emit_slot && !can_load) |=> $stable(cnt_q))
    else $error("emit advanced while output was stalled");
`endif

endmodule

### rtl/kf4_lane_ram.sv
// ----------------------------------------------------------------------------
// kf4_lane_ram
// Lane store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module kf4_lane_ram (
  input  logic             clk_i,
  input  kf4_pkg::ram_req_t req_i,
  output kf4_pkg::lane_t   rdata_o
);

  kf4_pkg::lane_t mem [kf4_pkg::NumLanes];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_o <= mem[req_i.raddr];
    end
  end

endmodule

### rtl/kf4_round.sv
// ----------------------------------------------------------------------------
// kf4_round
// One round of Keccak-f[400]: theta, rho, pi, chi and iota.
// ----------------------------------------------------------------------------
module kf4_round (
  input  kf4_pkg::state_t a_i,
  input  kf4_pkg::lane_t  rc_i,
  output kf4_pkg::state_t a_o
);

  kf4_pkg::lane_t c [5];
  kf4_pkg::lane_t d [5];
  kf4_pkg::state_t th;
  kf4_pkg::state_t b;

  for (genvar x = 0; x < 5; x++) begin : g_col
    assign c[x] = a_i[x] ^ a_i[x+5] ^ a_i[x+10] ^ a_i[x+15] ^ a_i[x+20];
  end

  for (genvar x = 0; x < 5; x++) begin : g_d
    assign d[x] = c[(x+4)%5] ^ kf4_pkg::rotl(c[(x+1)%5], 4'd1);
  end

  for (genvar x = 0; x < 5; x++) begin : g_x
    for (genvar y = 0; y < 5; y++) begin : g_y
      assign th[x+5*y] = a_i[x+5*y] ^ d[x];
      // pi moves lane (x, y) to (y, 2x + 3y)
      assign b[y+5*((2*x+3*y)%5)] = kf4_pkg::rotl(th[x+5*y], kf4_pkg::RhoOff[x+5*y]);
    end
  end

  for (genvar y = 0; y < 5; y++) begin : g_chi_y
    for (genvar x = 0; x < 5; x++) begin : g_chi_x
      if (x == 0 && y == 0) begin : g_iota
        assign a_o[0] = b[0] ^ (~b[1] & b[2]) ^ rc_i;
      end else begin : g_plain
        assign a_o[x+5*y] = b[x+5*y] ^ (~b[((x+1)%5)+5*y] & b[((x+2)%5)+5*y]);
      end
    end
  end

endmodule

### tb/keccak_f400_sponge_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keccak_f400_sponge_test
// Drives absorb, squeeze, clear and unused ops into the sponge under random
// gaps and back-pressure. Checks every squeezed lane against a local model.
// ----------------------------------------------------------------------------
module keccak_f400_sponge_test;

  localparam logic [1:0] OpUnused = 2'd3;
  localparam int IdleLimit  = 5000;
  localparam int SettleCyc  = 150;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  kf4_pkg::in_t              in_data_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  kf4_pkg::out_t             out_data_o;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic [kf4_pkg::RateW-1:0] cfg_data_i = '0;

  keccak_f400_sponge i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_data_i,
    .out_valid_o,
    .out_ready_i,
    .out_data_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_data_i
  );

  // Sponge model state.
  kf4_pkg::lane_t            lanes_m [kf4_pkg::NumLanes];
  logic [4:0]                widx_m;
  logic [kf4_pkg::RateW-1:0] rate_m;
  kf4_pkg::out_t             lane_q [$];

  int errors = 0;
  int idle_cycles = 0;
  int rx_hold = 0;
  bit rx_free = 1'b0;
  bit tx_free = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic kf4_pkg::lane_t rot16(kf4_pkg::lane_t v, int unsigned s);
    s = s % 16;
    if (s == 0) return v;
    return kf4_pkg::lane_t'((v << s) | (v >> (16 - s)));
  endfunction

  function automatic void permute_lanes();
    kf4_pkg::lane_t c [5];
    kf4_pkg::lane_t row [5];
    kf4_pkg::lane_t t, tmp;
    logic [7:0] lfsr;
    logic hi;
    int unsigned x, y, nx, j, rot;
    lfsr = 8'd1;
    for (int r = 0; r < kf4_pkg::Rounds; r++) begin
      for (int i = 0; i < 5; i++)
        c[i] = lanes_m[i] ^ lanes_m[i+5] ^ lanes_m[i+10] ^ lanes_m[i+15] ^ lanes_m[i+20];
      for (int i = 0; i < 5; i++) begin
        t = c[(i+4)%5] ^ rot16(c[(i+1)%5], 1);
        for (int k = 0; k < kf4_pkg::NumLanes; k += 5) lanes_m[k+i] ^= t;
      end
      x = 1; y = 0; rot = 0;
      t = lanes_m[1];
      for (int i = 0; i < kf4_pkg::MaxRate; i++) begin
        nx = y;
        y = (2*x + 3*y) % 5;
        x = nx;
        j = x + 5*y;
        rot += i + 1;
        tmp = lanes_m[j];
        lanes_m[j] = rot16(t, rot & 15);
        t = tmp;
      end
      for (int k = 0; k < kf4_pkg::NumLanes; k += 5) begin
        for (int i = 0; i < 5; i++) row[i] = lanes_m[k+i];
        for (int i = 0; i < 5; i++) lanes_m[k+i] ^= ~row[(i+1)%5] & row[(i+2)%5];
      end
      for (int i = 0; i < 7; i++) begin
        hi = lfsr[7];
        lfsr = (lfsr << 1) ^ (hi ? 8'd113 : 8'd0);
        if (lfsr[1] && i <= 4) lanes_m[0] ^= kf4_pkg::lane_t'(1) << ((1 << i) - 1);
      end
    end
  endfunction

  function automatic int unsigned rate_in_use();
    if (rate_m == 0) return 1;
    if (rate_m > kf4_pkg::MaxRate) return kf4_pkg::MaxRate;
    return 32'(rate_m);
  endfunction

  function automatic void sponge_step(kf4_pkg::in_t item);
    int unsigned rate, idx;
    kf4_pkg::out_t res;
    rate = rate_in_use();
    case (item.op)
      kf4_pkg::OpAbsorb: begin
        idx = 32'(widx_m);
        if (idx >= kf4_pkg::MaxRate) idx = 0;
        lanes_m[idx] ^= item.data_word;
        idx++;
        if (idx >= rate) begin
          permute_lanes();
          idx = 0;
        end
        widx_m = idx[4:0];
      end
      kf4_pkg::OpSqueeze: begin
        for (int k = 0; k < rate; k++) begin
          res.out_word = lanes_m[k];
          res.last = (k + 1 == rate);
          lane_q.push_back(res);
        end
        permute_lanes();
        widx_m = '0;
      end
      kf4_pkg::OpClear: begin
        foreach (lanes_m[i]) lanes_m[i] = '0;
        widx_m = '0;
      end
      default: ;
    endcase
  endfunction

  // Lane checker.
  always @(posedge clk_i) begin
    kf4_pkg::out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (lane_q.size() == 0) begin
        $error("unexpected beat: out_word %h last %b", out_data_o.out_word, out_data_o.last);
        errors++;
      end else begin
        want = lane_q.pop_front();
        if (out_data_o.out_word !== want.out_word) begin
          $error("out_word: expected %h, actual %h", want.out_word, out_data_o.out_word);
          errors++;
        end
        if (out_data_o.last !== want.last) begin
          $error("last: expected %b, actual %b", want.last, out_data_o.last);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("keccak_f400_sponge test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stalls, occasional long runs, forced hold-off.
  initial begin
    int run;
    run = 0;
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        out_ready_i <= 1'b0;
        rx_hold--;
      end else if (rx_free) begin
        out_ready_i <= 1'b1;
      end else if (run > 0) begin
        out_ready_i <= 1'b0;
        run--;
      end else if ($urandom_range(0, 99) == 0) begin
        out_ready_i <= 1'b0;
        run = $urandom_range(20, 80);
      end else begin
        out_ready_i <= ($urandom_range(0, 9) < 7);
      end
    end
  end

  task automatic send_item(logic [1:0] op, kf4_pkg::lane_t word);
    kf4_pkg::in_t item;
    item.op = op;
    item.data_word = word;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= item;
    do @(posedge clk_i); while (!in_ready_o);
    sponge_step(item);
  endtask

  // Gap after a beat; drops valid only when a gap is taken.
  task automatic sender_gap();
    int n;
    if (tx_free) return;
    if ($urandom_range(0, 29) == 0) n = $urandom_range(20, 60);
    else n = $urandom_range(0, 3);
    if (n == 0) return;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  task automatic send(logic [1:0] op, kf4_pkg::lane_t word);
    send_item(op, word);
    sender_gap();
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (lane_q.size() == 0);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_rate(logic [kf4_pkg::RateW-1:0] value);
    drain();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    rate_m = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_directed();
    send(kf4_pkg::OpSqueeze, '0);
    send(kf4_pkg::OpAbsorb, 16'hFFFF);
    send(kf4_pkg::OpAbsorb, 16'h0000);
    send(kf4_pkg::OpAbsorb, 16'hA5A5);
    send(kf4_pkg::OpSqueeze, 16'hFFFF);      // squeeze after a partial absorb
    send(OpUnused, 16'h1234);
    send(kf4_pkg::OpSqueeze, '0);
    send(kf4_pkg::OpClear, 16'hFFFF);
    send(kf4_pkg::OpSqueeze, '0);
    for (int i = 0; i < 8; i++) send(kf4_pkg::OpAbsorb, 16'(16'h0101 * i));
    send(kf4_pkg::OpSqueeze, '0);
    for (int i = 0; i < 5; i++) send(kf4_pkg::OpAbsorb, 16'($urandom_range(0, 65535)));
    write_rate(5'd3);                        // lower the rate mid-block
    send(kf4_pkg::OpAbsorb, 16'h8001);
    send(kf4_pkg::OpSqueeze, '0);
  endtask

  task automatic test_rate_extremes();
    logic [kf4_pkg::RateW-1:0] rates [5] = '{5'd1, 5'd24, 5'd0, 5'd31, 5'd25};
    foreach (rates[r]) begin
      write_rate(rates[r]);
      send(kf4_pkg::OpAbsorb, 16'hFFFF);
      send(kf4_pkg::OpAbsorb, 16'h7FFE);
      send(kf4_pkg::OpSqueeze, '0);
    end
  endtask

  task automatic test_random();
    int k;
    for (int blk = 0; blk < 40; blk++) begin
      if ($urandom_range(0, 5) == 0) begin
        if ($urandom_range(0, 3) == 0) write_rate(kf4_pkg::RateW'($urandom_range(0, 31)));
        else write_rate(kf4_pkg::RateW'($urandom_range(1, 8)));
      end
      tx_free = ($urandom_range(0, 4) == 0);
      rx_free = ($urandom_range(0, 4) == 0);
      k = $urandom_range(0, 2 * rate_in_use());
      for (int i = 0; i < k; i++) begin
        if ($urandom_range(0, 19) == 0)
          send(2'($urandom_range(2, 3)), 16'($urandom_range(0, 65535)));
        else
          send(kf4_pkg::OpAbsorb, 16'($urandom_range(0, 65535)));
      end
      send(kf4_pkg::OpSqueeze, 16'($urandom_range(0, 65535)));
    end
    tx_free = 1'b0;
    rx_free = 1'b0;
  endtask

  task automatic test_backpressure();
    write_rate(5'd24);
    tx_free = 1'b1;
    rx_hold = 600;
    for (int i = 0; i < 4; i++) begin
      send(kf4_pkg::OpAbsorb, 16'($urandom_range(0, 65535)));
      send(kf4_pkg::OpSqueeze, '0);
    end
    tx_free = 1'b0;
    // pause until every lane is out, then go on
    drain();
    write_rate(5'd2);
    for (int i = 0; i < 6; i++) send(kf4_pkg::OpAbsorb, 16'($urandom_range(0, 65535)));
    send(kf4_pkg::OpSqueeze, '0);
  endtask

  initial begin
    foreach (lanes_m[i]) lanes_m[i] = '0;
    widx_m = '0;
    rate_m = 5'd8;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_rate_extremes();
    test_random();
    test_backpressure();

    drain();
    if (lane_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("keccak_f400_sponge test passed");
    end else begin
      $display("keccak_f400_sponge test failed");
    end
    $finish;
  end

endmodule
